// ===== design/ir_adc_to_distance_interp_top_defines.svh =====
// assertion macros for the ir to distance top design file
`ifndef IR_ADC_TO_DISTANCE_INTERP_TOP_DEFINES_SVH
`define IR_ADC_TO_DISTANCE_INTERP_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define IR2D_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ir2d check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define IR2D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ir2d check failed");

`endif

// ===== design/ir2d_pkg.sv =====
// types, constants and calibration table for the ir to distance block
`timescale 1ns / 1ps

package ir2d_pkg;

	// table and field sizes
	localparam int TABLE_POINTS = 15;
	localparam int ADC_BITS     = 12;
	localparam int MM_W         = 7;
	localparam int DD_W         = 4;
	localparam int QUO_W        = DD_W;
	localparam int NUM_W        = ADC_BITS + DD_W + 1;
	localparam int IDX_W        = $clog2(TABLE_POINTS);
	localparam int MCNT_W       = $clog2(DD_W);
	localparam int QCNT_W       = $clog2(QUO_W);
	localparam int PADDR_W      = 4;

	// calibration points, raw descending, distance ascending
	localparam logic [ADC_BITS-1:0] CAL_RAW [TABLE_POINTS] = '{
		12'd1815, 12'd1554, 12'd1317, 12'd1158, 12'd1032,
		12'd957,  12'd880,  12'd801,  12'd735,  12'd700,
		12'd645,  12'd581,  12'd538,  12'd451,  12'd395
	};
	localparam logic [MM_W-1:0] CAL_MM [TABLE_POINTS] = '{
		7'd20, 7'd25, 7'd30, 7'd35, 7'd40,
		7'd45, 7'd50, 7'd55, 7'd60, 7'd65,
		7'd70, 7'd75, 7'd80, 7'd90, 7'd100
	};

	// register word indexes
	typedef enum logic [1:0] {
		REG_LEFT_OFFSET    = 2'd0,
		REG_RIGHT_OFFSET   = 2'd1,
		REG_WALL_THRESHOLD = 2'd2
	} ir2d_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIVGO,
		ST_DIV,
		ST_FIN
	} ir2d_state_t;

	// input item
	typedef struct packed {
		logic        side;
		logic [11:0] raw_adc;
	} ir2d_sample_t;

	// result item
	typedef struct packed {
		logic signed [7:0] range_mm;
		logic              wall_seen;
	} ir2d_result_t;

endpackage

// ===== design/ir2d_serdiv.sv =====
// restoring divider, one quotient bit per cycle for small quotients
`timescale 1ns / 1ps

module ir2d_serdiv
	import ir2d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [NUM_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic              run_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dvs_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ge;

	// trial subtract against the shifted divisor
	assign ge = (rem_q >= dvs_q);

	// step counter and completion strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= QCNT_W'(QUO_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder, divisor and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor << (QUO_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/ir_adc_to_distance_interp_top.sv =====
// ir sensor sample to millimetres by piecewise linear table lookup
`timescale 1ns / 1ps
`include "ir_adc_to_distance_interp_top_defines.svh"

// Usage:
// A sample (side, raw_adc) is taken at a clock edge where start is high and
// busy is low. busy stays high until the result has been produced. The result
// is shown on result, marked by done for exactly one cycle; the receiver has
// no way to hold it, so it must take the transfer in that cycle.
// Samples at or beyond either table end go straight to the result; samples
// inside segment k (k = 0 .. 13) first pass the search, the product and the
// divider. The segment search walks the table one point per cycle, the
// product is built by a 4-step shift-and-add and the rounded quotient by a
// 4-step restoring divider. busy drops in the done cycle, so the next start
// can be taken there; a new sample is taken only once the last is finished.
// Registers on the APB port: 0x0 left offset, 0x4 right offset, 0x8 wall
// threshold; the user must see that they are written only while busy is
// low, as the block itself does not enforce this. Reset clears the
// sequencer, the done strobe and all three registers to 0.

module ir_adc_to_distance_interp_top
	import ir2d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ir2d_sample_t       sample,
	output logic               done,
	output ir2d_result_t       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	ir2d_state_t         state_q, state_d;
	logic                done_q;
	logic [IDX_W-1:0]    idx_q;
	logic [MCNT_W-1:0]   mcnt_q;
	logic [MM_W-1:0]     left_off_q;
	logic [MM_W-1:0]     right_off_q;
	logic [7:0]          thr_q;

	logic                side_q;
	logic [ADC_BITS-1:0] raw_q;
	logic [MM_W-1:0]     mm_q;
	logic [ADC_BITS-1:0] den_q;
	logic [NUM_W-1:0]    mcand_q;
	logic [DD_W-1:0]     mplier_q;
	logic [NUM_W-1:0]    acc_q;
	ir2d_result_t        result_q;

	logic                accept;
	logic                cfg_wr;
	ir2d_reg_t           reg_sel;
	logic [ADC_BITS-1:0] raw_in;
	logic                clamp_far;
	logic                clamp_near;
	logic [IDX_W-1:0]    idx_nx;
	logic                hit;
	logic                div_start;
	logic                div_done;
	logic [QUO_W-1:0]    div_quo;
	logic [NUM_W-1:0]    div_dividend;
	logic [NUM_W-1:0]    div_divisor;
	logic [MM_W-1:0]     off_sel;
	logic signed [7:0]   corr_mm;

	// handshake and input decode
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign raw_in     = sample.raw_adc[ADC_BITS-1:0];
	assign clamp_far  = (raw_in <= CAL_RAW[TABLE_POINTS-1]);
	assign clamp_near = (raw_in >= CAL_RAW[0]);
	assign idx_nx     = idx_q + 1'b1;
	assign hit        = (raw_q >= CAL_RAW[idx_nx]);

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = ir2d_reg_t'(paddr[3:2]);

	always_comb begin
		case (reg_sel)
			REG_LEFT_OFFSET:    prdata = 32'(left_off_q);
			REG_RIGHT_OFFSET:   prdata = 32'(right_off_q);
			REG_WALL_THRESHOLD: prdata = 32'(thr_q);
			default:            prdata = '0;
		endcase
	end

	// next state and divider kick
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (clamp_far || clamp_near) ? ST_FIN : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (CAL_RAW[idx_q] == CAL_RAW[idx_nx]) ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == '0) begin
					state_d = ST_DIVGO;
				end
			end
			ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			idx_q       <= '0;
			mcnt_q      <= '0;
			left_off_q  <= '0;
			right_off_q <= '0;
			thr_q       <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == ST_SEARCH && !hit) begin
				idx_q <= idx_nx;
			end
			if (state_q == ST_SEARCH) begin
				mcnt_q <= MCNT_W'(DD_W - 1);
			end else if (state_q == ST_MUL) begin
				mcnt_q <= mcnt_q - 1'b1;
			end
			if (cfg_wr) begin
				case (reg_sel)
					REG_LEFT_OFFSET:    left_off_q  <= pwdata[MM_W-1:0];
					REG_RIGHT_OFFSET:   right_off_q <= pwdata[MM_W-1:0];
					REG_WALL_THRESHOLD: thr_q       <= pwdata[7:0];
					default:            ;
				endcase
			end
		end
	end

	// offset correction on the final distance, used by the wall compare
	assign off_sel = side_q ? right_off_q : left_off_q;
	assign corr_mm = $signed({1'b0, mm_q} - {1'b0, off_sel});

	// datapath: clamp, segment setup, shift-and-add product, result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					side_q <= sample.side;
					raw_q  <= raw_in;
					mm_q   <= clamp_far ? CAL_MM[TABLE_POINTS-1] : CAL_MM[0];
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					den_q    <= CAL_RAW[idx_q] - CAL_RAW[idx_nx];
					mcand_q  <= NUM_W'(CAL_RAW[idx_q] - raw_q) << 1;
					mplier_q <= DD_W'(CAL_MM[idx_nx] - CAL_MM[idx_q]);
					acc_q    <= '0;
					mm_q     <= CAL_MM[idx_q];
				end
			end
			ST_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_DIV: begin
				if (div_done) begin
					mm_q <= CAL_MM[idx_q] + MM_W'(div_quo);
				end
			end
			ST_FIN: begin
				result_q.range_mm  <= corr_mm;
				result_q.wall_seen <= ($signed({{2{corr_mm[7]}}, corr_mm}) <
					$signed({2'b00, thr_q}));
			end
			default: ;
		endcase
	end

	// rounded quotient (2*num + den) / (2*den)
	assign div_dividend = acc_q + NUM_W'(den_q);
	assign div_divisor  = NUM_W'({den_q, 1'b0});

	ir2d_serdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign done   = done_q;
	assign result = result_q;

	// checks
	`IR2D_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`IR2D_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`IR2D_ASSERT_NEXT(a_fin_done, state_q == ST_FIN, done_q)
	`IR2D_ASSERT_SAME(a_search_range, state_q == ST_SEARCH, idx_q < IDX_W'(TABLE_POINTS - 1))
	`IR2D_ASSERT_SAME(a_range_limit, done_q, result_q.range_mm <= 8'sd100)

endmodule

// ===== tb/sv/testbench.sv =====
// ir sample to distance testbench: table points, offsets, registers, then random samples
`timescale 1ns / 1ps

module testbench
	import ir2d_pkg::*;
;

	localparam int LAST_POINT = 14;
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = 4'hC;

	// calibration points, raw descending, distance ascending
	int cal_raw [15] = '{1815, 1554, 1317, 1158, 1032, 957, 880, 801, 735, 700,
		645, 581, 538, 451, 395};
	int cal_mm [15] = '{20, 25, 30, 35, 40, 45, 50, 55, 60, 65, 70, 75, 80, 90, 100};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	ir2d_sample_t       sample_bus = '0;
	logic               done;
	ir2d_result_t       result_bus;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// register copies for prediction
	logic [6:0] left_off = '0;
	logic [6:0] right_off = '0;
	logic [7:0] wall_thr = '0;

	ir2d_result_t pending_ranges[$];
	int fail_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;

	ir_adc_to_distance_interp_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sample  (sample_bus),
		.done    (done),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// upper bound on the whole run
	initial begin
		#8_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// raw sample to millimetres, then offset and wall compare
	function automatic ir2d_result_t predict_range(input ir2d_sample_t s);
		ir2d_result_t res;
		int raw, mm, corr_mm, den, num, i;
		bit found;
		raw = int'(s.raw_adc);
		mm = cal_mm[LAST_POINT];
		found = 1'b0;
		if (raw <= cal_raw[LAST_POINT]) begin
			mm = cal_mm[LAST_POINT];
		end else if (raw >= cal_raw[0]) begin
			mm = cal_mm[0];
		end else begin
			for (i = 0; i < LAST_POINT; i++) begin
				if (!found && raw <= cal_raw[i] && raw >= cal_raw[i+1]) begin
					found = 1'b1;
					den = cal_raw[i] - cal_raw[i+1];
					if (den == 0) begin
						mm = cal_mm[i];
					end else begin
						// half-up rounding in integers
						num = (cal_raw[i] - raw) * (cal_mm[i+1] - cal_mm[i]);
						mm = cal_mm[i] + (2 * num + den) / (2 * den);
					end
				end
			end
		end
		corr_mm = mm - (s.side ? int'(right_off) : int'(left_off));
		res.range_mm = corr_mm[7:0];
		res.wall_seen = (corr_mm < int'(wall_thr));
		return res;
	endfunction

	function automatic logic [PADDR_W-1:0] reg_addr(input ir2d_reg_t r);
		return PADDR_W'({r, 2'b00});
	endfunction

	// check each result transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		ir2d_result_t want;
		if (arst_n && done) begin
			if (pending_ranges.size() == 0) begin
				$error("result with no sample pending: range_mm %0d wall_seen %0b",
					$signed(result_bus.range_mm), result_bus.wall_seen);
				fail_count++;
			end else begin
				want = pending_ranges.pop_front();
				results_checked++;
				if (result_bus.range_mm !== want.range_mm) begin
					$error("range_mm expected %0d actual %0d",
						$signed(want.range_mm), $signed(result_bus.range_mm));
					fail_count++;
				end
				if (result_bus.wall_seen !== want.wall_seen) begin
					$error("wall_seen expected %0b actual %0b",
						want.wall_seen, result_bus.wall_seen);
					fail_count++;
				end
			end
		end
	end

	// one sample transfer; start is left high for a following item
	task automatic send_sample(input logic side_sel, input logic [11:0] raw);
		ir2d_sample_t s;
		s.side = side_sel;
		s.raw_adc = raw;
		sample_bus <= s;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_ranges.push_back(predict_range(s));
		samples_sent++;
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait for every pending result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_ranges.size() != 0);
	endtask

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 40);
	endfunction

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
		if (addr == reg_addr(REG_LEFT_OFFSET))
			left_off = data[6:0];
		else if (addr == reg_addr(REG_RIGHT_OFFSET))
			right_off = data[6:0];
		else if (addr == reg_addr(REG_WALL_THRESHOLD))
			wall_thr = data[7:0];
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// read back all three registers
	task automatic check_registers();
		logic [31:0] v;
		apb_read(reg_addr(REG_LEFT_OFFSET), v);
		if (v !== {25'b0, left_off}) begin
			$error("left_offset_mm expected %0d actual %0d", left_off, v);
			fail_count++;
		end
		apb_read(reg_addr(REG_RIGHT_OFFSET), v);
		if (v !== {25'b0, right_off}) begin
			$error("right_offset_mm expected %0d actual %0d", right_off, v);
			fail_count++;
		end
		apb_read(reg_addr(REG_WALL_THRESHOLD), v);
		if (v !== {24'b0, wall_thr}) begin
			$error("wall_threshold_mm expected %0d actual %0d", wall_thr, v);
			fail_count++;
		end
	endtask

	task automatic set_ranges(input logic [31:0] lo, input logic [31:0] ro,
		input logic [31:0] th);
		drain();
		apb_write(reg_addr(REG_LEFT_OFFSET), lo);
		apb_write(reg_addr(REG_RIGHT_OFFSET), ro);
		apb_write(reg_addr(REG_WALL_THRESHOLD), th);
		check_registers();
	endtask

	// random sample, weighted toward the table span and its points
	function automatic logic [11:0] pick_raw();
		int sel, pt;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 12'($urandom_range(380, 1830));
		pt = $urandom_range(0, LAST_POINT);
		if (sel < 75)
			return 12'(cal_raw[pt] + $urandom_range(0, 4) - 2);
		return 12'($urandom);
	endfunction

	task automatic test_reset_values();
		check_registers();
	endtask

	// table ends, every inner point and an exact half in rounding
	task automatic test_table_points();
		int i;
		send_sample(1'b0, 12'd0);
		send_sample(1'b1, 12'hFFF);
		send_sample(1'b0, 12'(cal_raw[LAST_POINT]));
		send_sample(1'b1, 12'(cal_raw[0]));
		for (i = 1; i < LAST_POINT; i++) begin
			send_sample(1'(i), 12'(cal_raw[i]));
			idle_cycles(gap_len());
		end
		// 1095 sits at exactly 2.5 mm into the 35..40 segment
		send_sample(1'b0, 12'd1095);
		drain();
	endtask

	// large offsets, up to the largest, drive results to zero or below; threshold at both ends
	task automatic test_offsets_and_wall();
		set_ranges(32'd127, 32'd100, 32'd255);
		send_sample(1'b0, 12'd0);
		send_sample(1'b0, 12'hFFF);
		send_sample(1'b1, 12'd0);
		send_sample(1'b1, 12'hFFF);
		set_ranges(32'd0, 32'd127, 32'd0);
		send_sample(1'b1, 12'd0);
		send_sample(1'b0, 12'd0);
		drain();
	endtask

	// bits above a register's width are dropped; an unmapped write changes nothing
	task automatic test_register_map();
		set_ranges(32'hFFFF_FF85, 32'hAAAA_AAAA, 32'h1234_5680);
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		check_registers();
	endtask

	task automatic test_random_samples();
		int phase, n, mode;
		bit back_to_back;
		for (phase = 0; phase < 10; phase++) begin
			mode = (phase < 2) ? phase : $urandom_range(0, 3);
			case (mode)
				0: set_ranges(32'd127, 32'd127, 32'd255);
				1: set_ranges(32'd0, 32'd0, 32'd0);
				2: set_ranges($urandom_range(0, 100), $urandom_range(0, 100),
					$urandom_range(0, 255));
				default: set_ranges($urandom, $urandom, $urandom);
			endcase
			back_to_back = ($urandom_range(0, 3) == 0);
			for (n = 0; n < 200; n++) begin
				send_sample(1'($urandom), pick_raw());
				if (phase == 4 && n == 100)
					drain();
				else if (!back_to_back)
					idle_cycles(gap_len());
			end
		end
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_table_points();
		test_offsets_and_wall();
		test_register_map();
		test_random_samples();
		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d samples on both sides, %0d register writes with readback",
			samples_sent, reg_writes);
		$display("%0d results checked: table ends, inner points, rounding, offsets, wall",
			results_checked);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
